// ===== rtl/core/dasc_pkg.sv =====
// Package for the dual alarm snooze controller core.
// Holds field widths, reset values, register indexes and shared types.
// No dependencies.
package dasc_pkg;

	localparam int HourW        = 5;
	localparam int MinuteW      = 6;
	localparam int SnoozeTicksW = 20;
	localparam int ToneTicksW   = 16;
	localparam int ElapsedW     = 17;
	localparam int NoteW        = 2;
	localparam int RingW        = 2;
	localparam int CfgIndexW    = 3;
	localparam int CfgDataW     = 20;
	localparam int InDataW      = 16;
	localparam int OutDataW     = 8;

	localparam int SNOOZE_WIDTH_DEFAULT = 20;

	localparam logic [SnoozeTicksW-1:0] SnoozeTicksRst = SnoozeTicksW'(5 * 60 * 1000);
	localparam logic [ToneTicksW-1:0]   ToneTicksRst   = ToneTicksW'(100);

	localparam logic [CfgIndexW-1:0] RegAlarm1Hour   = 3'd0;
	localparam logic [CfgIndexW-1:0] RegAlarm1Minute = 3'd1;
	localparam logic [CfgIndexW-1:0] RegAlarm1Enable = 3'd2;
	localparam logic [CfgIndexW-1:0] RegAlarm2Hour   = 3'd3;
	localparam logic [CfgIndexW-1:0] RegAlarm2Minute = 3'd4;
	localparam logic [CfgIndexW-1:0] RegAlarm2Enable = 3'd5;
	localparam logic [CfgIndexW-1:0] RegSnoozeTicks  = 3'd6;
	localparam logic [CfgIndexW-1:0] RegToneTicks    = 3'd7;

	localparam logic [RingW-1:0] RingNone   = 2'd0;
	localparam logic [RingW-1:0] RingFirst  = 2'd1;
	localparam logic [RingW-1:0] RingSecond = 2'd2;

	localparam logic [NoteW-1:0] NoteFirst = 2'd0;
	localparam logic [NoteW-1:0] NoteLast  = 2'd2;

	typedef struct packed {
		logic [HourW-1:0]   hour;
		logic [MinuteW-1:0] minute;
		logic               snooze;
		logic               stop;
	} tick_t;

	typedef struct packed {
		logic [HourW-1:0]   hour;
		logic [MinuteW-1:0] minute;
		logic               enable;
	} alarm_cfg_t;

	typedef struct packed {
		logic ringing;
		logic snoozed;
	} alarm_flags_t;

endpackage

// ===== rtl/core/dasc_alarm.sv =====
// One alarm channel: ringing, snoozed and stopped flags plus snooze counter.
// Computes the per-tick next state and holds it on advance.
// Depends on dasc_pkg.
module dasc_alarm #(
	parameter int SNOOZE_WIDTH = dasc_pkg::SNOOZE_WIDTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic                                step_en,
	input  dasc_pkg::alarm_cfg_t                cfg,
	input  logic [dasc_pkg::SnoozeTicksW-1:0]   snooze_ticks,
	input  dasc_pkg::tick_t                     tick,
	output dasc_pkg::alarm_flags_t              flags,
	output dasc_pkg::alarm_flags_t              flags_next
);

	localparam int CmpW = (SNOOZE_WIDTH > dasc_pkg::SnoozeTicksW) ?
		SNOOZE_WIDTH : dasc_pkg::SnoozeTicksW;

	logic                    ringing_q, snoozed_q, stopped_q;
	logic [SNOOZE_WIDTH-1:0] count_q;

	logic                    count_sat;
	logic [SNOOZE_WIDTH-1:0] count_inc;
	logic                    match;
	logic                    r1, st1;
	logic                    r2, sn2, st2;
	logic [SNOOZE_WIDTH-1:0] c2;
	logic                    ring_n, snz_n, stop_n;
	logic [SNOOZE_WIDTH-1:0] count_n;

	assign count_sat = (count_q == {SNOOZE_WIDTH{1'b1}});
	assign count_inc = (snoozed_q && !count_sat) ? count_q + 1'b1 : count_q;
	assign match     = cfg.enable && (tick.hour == cfg.hour) && (tick.minute == cfg.minute);

	always_comb begin
		r1  = ringing_q;
		st1 = stopped_q;
		if (match) begin
			if (!ringing_q && !snoozed_q && !stopped_q)
				r1 = 1'b1;
		end else begin
			st1 = 1'b0;
		end

		r2  = r1;
		sn2 = snoozed_q;
		st2 = st1;
		c2  = count_inc;
		if (r1) begin
			if (tick.snooze) begin
				sn2 = 1'b1;
				c2  = '0;
				r2  = 1'b0;
			end else if (tick.stop) begin
				st2 = 1'b1;
				r2  = 1'b0;
			end
		end

		if (step_en) begin
			ring_n  = r2;
			snz_n   = sn2;
			stop_n  = st2;
			count_n = c2;
			if (sn2 && (CmpW'(c2) > CmpW'(snooze_ticks))) begin
				snz_n  = 1'b0;
				ring_n = 1'b1;
			end
		end else begin
			ring_n  = ringing_q;
			snz_n   = snoozed_q;
			stop_n  = stopped_q;
			count_n = count_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ringing_q <= 1'b0;
			snoozed_q <= 1'b0;
			stopped_q <= 1'b0;
			count_q   <= '0;
		end else if (advance) begin
			ringing_q <= ring_n;
			snoozed_q <= snz_n;
			stopped_q <= stop_n;
			count_q   <= count_n;
		end
	end

	assign flags.ringing      = ringing_q;
	assign flags.snoozed      = snoozed_q;
	assign flags_next.ringing = ring_n;
	assign flags_next.snoozed = snz_n;

endmodule

// ===== rtl/core/dasc_tone.sv =====
// Note sequencer: cycles the buzzer note while the same alarm keeps ringing.
// Holds note index and elapsed tick count; restarts on silence or hand-over.
// Depends on dasc_pkg.
module dasc_tone (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  logic [dasc_pkg::RingW-1:0]         ring_before,
	input  logic [dasc_pkg::RingW-1:0]         ring_now,
	input  logic [dasc_pkg::ToneTicksW-1:0]    tone_ticks,
	output logic [dasc_pkg::NoteW-1:0]         note_next
);

	logic [dasc_pkg::NoteW-1:0]    note_q, note_n;
	logic [dasc_pkg::ElapsedW-1:0] elapsed_q, elapsed_n, elapsed_inc;

	assign elapsed_inc = (elapsed_q != {dasc_pkg::ElapsedW{1'b1}}) ?
		elapsed_q + 1'b1 : elapsed_q;

	always_comb begin
		note_n    = note_q;
		elapsed_n = elapsed_inc;
		if (ring_now == dasc_pkg::RingNone || ring_now != ring_before) begin
			note_n    = dasc_pkg::NoteFirst;
			elapsed_n = '0;
		end else if (elapsed_inc > dasc_pkg::ElapsedW'(tone_ticks)) begin
			note_n    = (note_q >= dasc_pkg::NoteLast) ? dasc_pkg::NoteFirst : note_q + 1'b1;
			elapsed_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_q    <= dasc_pkg::NoteFirst;
			elapsed_q <= '0;
		end else if (advance) begin
			note_q    <= note_n;
			elapsed_q <= elapsed_n;
		end
	end

	assign note_next = note_n;

endmodule

// ===== rtl/core/dual_alarm_snooze_controller_core.sv =====
// Top level of the dual alarm snooze controller core.
// Instantiates dasc_alarm (twice) and dasc_tone; depends on dasc_pkg.
//
// Usage:
//   Input stream s_axis_*: one transfer per millisecond tick carrying the
//   current hour and minute and the snooze and stop button levels.
//   Output stream m_axis_*: one transfer per input transfer with buzzer on,
//   note select, ringing alarm and both snoozed flags.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index (alarm
//   times, enables, snooze and tone lengths); write only while idle.
// Timing:
//   An accepted tick is registered in the input stage, evaluated by the
//   combinational flag logic, compares and counter increments, and its
//   result is loaded into the output register. Throughput is one tick per
//   cycle while m_axis_tready stays high.
// Reset: arst_n clears all alarm flags, counters and the note sequencer;
//   snooze length returns to 300000 ticks, tone length to 100, the rest to 0.
// Stall: while m_axis_tready is low the result holds; one more tick waits in
//   the input stage, after which s_axis_tready drops.
module dual_alarm_snooze_controller_core #(
	parameter int SNOOZE_WIDTH = dasc_pkg::SNOOZE_WIDTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [4:0] now_hour, [10:5] now_minute, [11] snooze_pressed, [12] stop_pressed
	input  logic [dasc_pkg::InDataW-1:0]       s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] buzzer_on, [2:1] note_select, [4:3] ringing_alarm,
	// [5] alarm1_is_snoozed, [6] alarm2_is_snoozed
	output logic [dasc_pkg::OutDataW-1:0]      m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [dasc_pkg::CfgIndexW-1:0]     cfg_index,
	input  logic [dasc_pkg::CfgDataW-1:0]      cfg_wdata
);

	dasc_pkg::alarm_cfg_t              a1_cfg_q, a2_cfg_q;
	logic [dasc_pkg::SnoozeTicksW-1:0] snooze_ticks_q;
	logic [dasc_pkg::ToneTicksW-1:0]   tone_ticks_q;

	logic                   valid_s1;
	dasc_pkg::tick_t        tick_s1;
	logic                   out_valid_q;
	logic [dasc_pkg::OutDataW-1:0] out_data_q;
	logic                   advance;

	dasc_pkg::alarm_flags_t a1_flags, a1_next, a2_flags, a2_next;
	logic [dasc_pkg::RingW-1:0] ring_before, ring_now;
	logic [dasc_pkg::NoteW-1:0] note_next, note_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1_cfg_q       <= '0;
			a2_cfg_q       <= '0;
			snooze_ticks_q <= dasc_pkg::SnoozeTicksRst;
			tone_ticks_q   <= dasc_pkg::ToneTicksRst;
		end else if (cfg_we) begin
			case (cfg_index)
				dasc_pkg::RegAlarm1Hour:   a1_cfg_q.hour   <= cfg_wdata[dasc_pkg::HourW-1:0];
				dasc_pkg::RegAlarm1Minute: a1_cfg_q.minute <= cfg_wdata[dasc_pkg::MinuteW-1:0];
				dasc_pkg::RegAlarm1Enable: a1_cfg_q.enable <= cfg_wdata[0];
				dasc_pkg::RegAlarm2Hour:   a2_cfg_q.hour   <= cfg_wdata[dasc_pkg::HourW-1:0];
				dasc_pkg::RegAlarm2Minute: a2_cfg_q.minute <= cfg_wdata[dasc_pkg::MinuteW-1:0];
				dasc_pkg::RegAlarm2Enable: a2_cfg_q.enable <= cfg_wdata[0];
				dasc_pkg::RegSnoozeTicks:  snooze_ticks_q  <= cfg_wdata[dasc_pkg::SnoozeTicksW-1:0];
				dasc_pkg::RegToneTicks:    tone_ticks_q    <= cfg_wdata[dasc_pkg::ToneTicksW-1:0];
				default: ;
			endcase
		end
	end

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			tick_s1.hour   <= s_axis_tdata[4:0];
			tick_s1.minute <= s_axis_tdata[10:5];
			tick_s1.snooze <= s_axis_tdata[11];
			tick_s1.stop   <= s_axis_tdata[12];
		end
	end

	dasc_alarm #(.SNOOZE_WIDTH(SNOOZE_WIDTH)) u_alarm1 (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.step_en      (1'b1),
		.cfg          (a1_cfg_q),
		.snooze_ticks (snooze_ticks_q),
		.tick         (tick_s1),
		.flags        (a1_flags),
		.flags_next   (a1_next)
	);

	dasc_alarm #(.SNOOZE_WIDTH(SNOOZE_WIDTH)) u_alarm2 (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.step_en      (!a1_next.ringing),
		.cfg          (a2_cfg_q),
		.snooze_ticks (snooze_ticks_q),
		.tick         (tick_s1),
		.flags        (a2_flags),
		.flags_next   (a2_next)
	);

	assign ring_before = a1_flags.ringing ? dasc_pkg::RingFirst :
		(a2_flags.ringing ? dasc_pkg::RingSecond : dasc_pkg::RingNone);
	assign ring_now = a1_next.ringing ? dasc_pkg::RingFirst :
		(a2_next.ringing ? dasc_pkg::RingSecond : dasc_pkg::RingNone);

	dasc_tone u_tone (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.ring_before (ring_before),
		.ring_now    (ring_now),
		.tone_ticks  (tone_ticks_q),
		.note_next   (note_next)
	);

	assign note_out = (ring_now != dasc_pkg::RingNone) ? note_next : dasc_pkg::NoteFirst;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {1'b0, a2_next.snoozed, a1_next.snoozed, ring_now, note_out,
				ring_now != dasc_pkg::RingNone};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== verif/tb_top.sv =====
// Testbench for dual_alarm_snooze_controller_core: directed and random tick streams
// with random stalls on both sides, checked against an in-bench alarm/snooze/note model.
// Depends on dasc_pkg and the core RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 200000;
	localparam int ItemsPerPhase = 100;
	localparam int RandomPhases = 10;

	typedef struct packed {
		logic                         snoozed2;
		logic                         snoozed1;
		logic [dasc_pkg::RingW-1:0]   ring;
		logic [dasc_pkg::NoteW-1:0]   note;
		logic                         buzzer;
	} chime_t;

	typedef struct {
		logic                                          ringing;
		logic                                          snoozed;
		logic                                          stopped;
		logic [dasc_pkg::SNOOZE_WIDTH_DEFAULT-1:0]     count;
	} alarm_st_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [dasc_pkg::InDataW-1:0]   s_axis_tdata = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [dasc_pkg::OutDataW-1:0]  m_axis_tdata;
	logic                           cfg_we = 1'b0;
	logic [dasc_pkg::CfgIndexW-1:0] cfg_index = '0;
	logic [dasc_pkg::CfgDataW-1:0]  cfg_wdata = '0;

	dasc_pkg::alarm_cfg_t              alarm_set [2];
	alarm_st_t                         alarm_st [2];
	logic [dasc_pkg::SnoozeTicksW-1:0] snooze_len;
	logic [dasc_pkg::ToneTicksW-1:0]   tone_len;
	logic [dasc_pkg::NoteW-1:0]        note_idx;
	logic [dasc_pkg::ElapsedW-1:0]     note_el;

	chime_t chime_q [$];
	int     errors = 0;
	int     cycle_count = 0;
	bit     no_idle = 1'b0;

	dual_alarm_snooze_controller_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic void reset_model();
		for (int i = 0; i < 2; i++) begin
			alarm_set[i] = '0;
			alarm_st[i] = '{ringing: 1'b0, snoozed: 1'b0, stopped: 1'b0, count: '0};
		end
		snooze_len = dasc_pkg::SnoozeTicksRst;
		tone_len = dasc_pkg::ToneTicksRst;
		note_idx = dasc_pkg::NoteFirst;
		note_el = '0;
	endfunction

	function automatic void apply_reg(input logic [dasc_pkg::CfgIndexW-1:0] idx,
			input logic [dasc_pkg::CfgDataW-1:0] val);
		case (idx)
			dasc_pkg::RegAlarm1Hour:   alarm_set[0].hour = val[dasc_pkg::HourW-1:0];
			dasc_pkg::RegAlarm1Minute: alarm_set[0].minute = val[dasc_pkg::MinuteW-1:0];
			dasc_pkg::RegAlarm1Enable: alarm_set[0].enable = val[0];
			dasc_pkg::RegAlarm2Hour:   alarm_set[1].hour = val[dasc_pkg::HourW-1:0];
			dasc_pkg::RegAlarm2Minute: alarm_set[1].minute = val[dasc_pkg::MinuteW-1:0];
			dasc_pkg::RegAlarm2Enable: alarm_set[1].enable = val[0];
			dasc_pkg::RegSnoozeTicks:  snooze_len = val[dasc_pkg::SnoozeTicksW-1:0];
			dasc_pkg::RegToneTicks:    tone_len = val[dasc_pkg::ToneTicksW-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [dasc_pkg::RingW-1:0] ringer();
		if (alarm_st[0].ringing)
			return dasc_pkg::RingFirst;
		if (alarm_st[1].ringing)
			return dasc_pkg::RingSecond;
		return dasc_pkg::RingNone;
	endfunction

	function automatic void advance_alarm(input int i, input dasc_pkg::tick_t t);
		if (alarm_set[i].enable && t.hour == alarm_set[i].hour
				&& t.minute == alarm_set[i].minute) begin
			if (!alarm_st[i].ringing && !alarm_st[i].snoozed && !alarm_st[i].stopped)
				alarm_st[i].ringing = 1'b1;
		end else if (alarm_st[i].stopped) begin
			alarm_st[i].stopped = 1'b0;
		end
		if (alarm_st[i].ringing) begin
			if (t.snooze) begin
				alarm_st[i].snoozed = 1'b1;
				alarm_st[i].count = '0;
				alarm_st[i].ringing = 1'b0;
			end else if (t.stop) begin
				alarm_st[i].stopped = 1'b1;
				alarm_st[i].ringing = 1'b0;
			end
		end
		if (alarm_st[i].snoozed && alarm_st[i].count > snooze_len) begin
			alarm_st[i].snoozed = 1'b0;
			alarm_st[i].ringing = 1'b1;
		end
	endfunction

	function automatic chime_t predict_chime(input dasc_pkg::tick_t t);
		logic [dasc_pkg::RingW-1:0] was_ringing;
		logic [dasc_pkg::RingW-1:0] is_ringing;
		chime_t c;
		was_ringing = ringer();
		for (int i = 0; i < 2; i++)
			if (alarm_st[i].snoozed && alarm_st[i].count != '1)
				alarm_st[i].count++;
		advance_alarm(0, t);
		if (!alarm_st[0].ringing)
			advance_alarm(1, t);
		is_ringing = ringer();
		if (is_ringing == dasc_pkg::RingNone || is_ringing != was_ringing) begin
			note_idx = dasc_pkg::NoteFirst;
			note_el = '0;
		end else begin
			if (note_el != '1)
				note_el++;
			if (note_el > tone_len) begin
				note_idx = (note_idx >= dasc_pkg::NoteLast) ? dasc_pkg::NoteFirst :
					note_idx + 2'd1;
				note_el = '0;
			end
		end
		c.buzzer = (is_ringing != dasc_pkg::RingNone);
		c.note = (is_ringing != dasc_pkg::RingNone) ? note_idx : dasc_pkg::NoteFirst;
		c.ring = is_ringing;
		c.snoozed1 = alarm_st[0].snoozed;
		c.snoozed2 = alarm_st[1].snoozed;
		return c;
	endfunction

	task automatic send_tick(input logic [dasc_pkg::HourW-1:0] h,
			input logic [dasc_pkg::MinuteW-1:0] m, input logic snz, input logic stp);
		int gap;
		dasc_pkg::tick_t t;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		t = '{hour: h, minute: m, snooze: snz, stop: stp};
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, stp, snz, m, h};
		do @(posedge clk); while (!s_axis_tready);
		chime_q.push_back(predict_chime(t));
	endtask

	// hold the sender until every pending result is back, then let the pipe empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (chime_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [dasc_pkg::CfgIndexW-1:0] idx,
			input logic [dasc_pkg::CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		apply_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [dasc_pkg::CfgDataW-1:0] h1,
			input logic [dasc_pkg::CfgDataW-1:0] m1, input logic [dasc_pkg::CfgDataW-1:0] e1,
			input logic [dasc_pkg::CfgDataW-1:0] h2, input logic [dasc_pkg::CfgDataW-1:0] m2,
			input logic [dasc_pkg::CfgDataW-1:0] e2, input logic [dasc_pkg::CfgDataW-1:0] snz,
			input logic [dasc_pkg::CfgDataW-1:0] tone);
		write_reg(dasc_pkg::RegAlarm1Hour, h1);
		write_reg(dasc_pkg::RegAlarm1Minute, m1);
		write_reg(dasc_pkg::RegAlarm1Enable, e1);
		write_reg(dasc_pkg::RegAlarm2Hour, h2);
		write_reg(dasc_pkg::RegAlarm2Minute, m2);
		write_reg(dasc_pkg::RegAlarm2Enable, e2);
		write_reg(dasc_pkg::RegSnoozeTicks, snz);
		write_reg(dasc_pkg::RegToneTicks, tone);
	endtask

	task automatic test_reset_state();
		send_tick(5'd0, 6'd0, 1'b0, 1'b0);
		send_tick(5'd0, 6'd0, 1'b1, 1'b1);
	endtask

	task automatic test_ring_and_notes();
		settle();
		configure(20'd23, 20'd59, 20'd1, 20'd0, 20'd0, 20'd0, 20'd2, 20'd0);
		repeat (4) send_tick(5'd23, 6'd59, 1'b0, 1'b0);
	endtask

	task automatic test_snooze_and_stop();
		send_tick(5'd23, 6'd59, 1'b1, 1'b0);
		repeat (3) send_tick(5'd23, 6'd59, 1'b0, 1'b0);
		send_tick(5'd23, 6'd59, 1'b1, 1'b1);
		repeat (3) send_tick(5'd23, 6'd59, 1'b0, 1'b0);
		send_tick(5'd23, 6'd59, 1'b0, 1'b1);
		send_tick(5'd23, 6'd59, 1'b0, 1'b0);
		send_tick(5'd31, 6'd63, 1'b0, 1'b0);
		send_tick(5'd23, 6'd59, 1'b0, 1'b0);
	endtask

	task automatic test_both_alarms();
		settle();
		write_reg(dasc_pkg::RegAlarm2Hour, 20'd23);
		write_reg(dasc_pkg::RegAlarm2Minute, 20'd58);
		write_reg(dasc_pkg::RegAlarm2Enable, 20'd1);
		write_reg(dasc_pkg::RegToneTicks, 20'd1);
		send_tick(5'd23, 6'd58, 1'b0, 1'b0);
		send_tick(5'd23, 6'd58, 1'b0, 1'b0);
		send_tick(5'd23, 6'd59, 1'b0, 1'b0);
		send_tick(5'd23, 6'd59, 1'b0, 1'b1);
		send_tick(5'd0, 6'd0, 1'b0, 1'b0);
	endtask

	task automatic test_register_extremes();
		settle();
		configure(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'h00000, 20'h00000, 20'hFFFFE,
			20'd1048574, 20'hFFFFE);
		send_tick(5'd31, 6'd63, 1'b0, 1'b0);
		send_tick(5'd31, 6'd63, 1'b1, 1'b0);
		settle();
		write_reg(dasc_pkg::RegSnoozeTicks, 20'h00000);
		write_reg(dasc_pkg::RegToneTicks, 20'hF0000);
		send_tick(5'd31, 6'd63, 1'b0, 1'b0);
		send_tick(5'd31, 6'd63, 1'b0, 1'b0);
	endtask

	function automatic logic [dasc_pkg::CfgDataW-1:0] pick_snooze_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return dasc_pkg::CfgDataW'($urandom_range(0, 12));
		if (r < 90)
			return 20'd1048574;
		if (r < 95)
			return 20'hFFFFF;
		return dasc_pkg::CfgDataW'($urandom);
	endfunction

	function automatic logic [dasc_pkg::CfgDataW-1:0] pick_tone_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return {4'($urandom_range(0, 15)), 16'($urandom_range(0, 6))};
		if (r < 88)
			return 20'd65534;
		if (r < 94)
			return 20'hFFFFF;
		return dasc_pkg::CfgDataW'($urandom);
	endfunction

	task automatic test_random_phases();
		logic [dasc_pkg::CfgDataW-1:0] h1, m1, h2, m2, e1, e2;
		logic [dasc_pkg::HourW-1:0]    h;
		logic [dasc_pkg::MinuteW-1:0]  m;
		int sent, run, r;
		for (int phase = 0; phase < RandomPhases; phase++) begin
			settle();
			h1 = dasc_pkg::CfgDataW'(($urandom_range(0, 3) == 0) ? $urandom :
				$urandom_range(0, 23));
			m1 = dasc_pkg::CfgDataW'(($urandom_range(0, 3) == 0) ? $urandom :
				$urandom_range(0, 59));
			h2 = dasc_pkg::CfgDataW'(($urandom_range(0, 3) == 0) ? $urandom :
				$urandom_range(0, 23));
			m2 = dasc_pkg::CfgDataW'(($urandom_range(0, 3) == 0) ? $urandom :
				$urandom_range(0, 59));
			if ($urandom_range(0, 9) < 3) begin
				h2 = h1;
				m2 = m1;
			end
			e1 = dasc_pkg::CfgDataW'({$urandom, 1'($urandom_range(0, 4) != 0)});
			e2 = dasc_pkg::CfgDataW'({$urandom, 1'($urandom_range(0, 4) != 0)});
			configure(h1, m1, e1, h2, m2, e2, pick_snooze_len(), pick_tone_len());
			no_idle = ($urandom_range(0, 3) == 0);
			sent = 0;
			while (sent < ItemsPerPhase) begin
				run = $urandom_range(1, 25);
				r = $urandom_range(0, 99);
				if (r < 40) begin
					h = alarm_set[0].hour;
					m = alarm_set[0].minute;
				end else if (r < 70) begin
					h = alarm_set[1].hour;
					m = alarm_set[1].minute;
				end else if (r < 80) begin
					h = alarm_set[0].hour;
					m = alarm_set[0].minute + 6'd1;
				end else begin
					h = dasc_pkg::HourW'($urandom_range(0, 31));
					m = dasc_pkg::MinuteW'($urandom_range(0, 63));
				end
				for (int k = 0; k < run && sent < ItemsPerPhase; k++) begin
					send_tick(h, m, $urandom_range(0, 99) < 6, $urandom_range(0, 99) < 6);
					sent++;
				end
			end
			no_idle = 1'b0;
		end
	endtask

	always @(posedge clk) begin : check_result
		chime_t want;
		chime_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[6:0];
			if (chime_q.size() == 0) begin
				errors++;
				$error("result transfer with no result pending: %h", m_axis_tdata);
			end else begin
				want = chime_q.pop_front();
				if (got.buzzer !== want.buzzer) begin
					errors++;
					$error("buzzer_on: expected %0d, got %0d", want.buzzer, got.buzzer);
				end
				if (got.note !== want.note) begin
					errors++;
					$error("note_select: expected %0d, got %0d", want.note, got.note);
				end
				if (got.ring !== want.ring) begin
					errors++;
					$error("ringing_alarm: expected %0d, got %0d", want.ring, got.ring);
				end
				if (got.snoozed1 !== want.snoozed1) begin
					errors++;
					$error("alarm1_is_snoozed: expected %0d, got %0d", want.snoozed1,
						got.snoozed1);
				end
				if (got.snoozed2 !== want.snoozed2) begin
					errors++;
					$error("alarm2_is_snoozed: expected %0d, got %0d", want.snoozed2,
						got.snoozed2);
				end
			end
		end
	end

	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL dual_alarm_snooze_controller_core");
		$finish;
	end

	initial begin
		reset_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_ring_and_notes();
		test_snooze_and_stop();
		test_both_alarms();
		test_register_extremes();
		test_random_phases();
		settle();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("PASS dual_alarm_snooze_controller_core");
		end else begin
			$display("FAIL dual_alarm_snooze_controller_core");
		end
		$finish;
	end

endmodule
